/* rtl/core/tlscr_pkg.sv */
// shared widths, protocol constants and status codes of the certificate request parser
`default_nettype none

package tlscr_pkg;

  localparam int unsigned PosW    = 25;
  localparam int unsigned BodyW   = 24;
  localparam int unsigned CtxW    = 8;
  localparam int unsigned XlenW   = 16;
  localparam int unsigned XposW   = 17;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned StatusW = 2;

  localparam logic [7:0]  TYPE_CERT_REQ = 8'h0d;
  localparam logic [15:0] EXT_SIG_ALGS  = 16'h000d;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_HDR   = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD_FRAME = 2'd2;
  localparam logic [StatusW-1:0] ST_NO_LIST   = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/tlscr_if.sv */
// valid/ready channels for message words and parse results
`default_nettype none

interface tlscr_msg_if import tlscr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlscr_res_if import tlscr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [CtxW-1:0]    context_length;
  logic [OffsetW-1:0] schemes_offset;
  logic [XlenW-1:0]   schemes_length;

  modport source (output valid, output status, output context_length,
                  output schemes_offset, output schemes_length, input ready);
  modport sink (input valid, input status, input context_length,
                input schemes_offset, input schemes_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/tls_certificate_request_parser.sv */
// top level: streaming tls 1.3 certificate request parser
`default_nettype none

// Takes one message word (byte) per clock on msg and, on the word marked last_byte,
// loads one result into an output register on result: status, context length and the
// offset and length of the signature algorithms scheme list. Every word is parsed in
// the cycle it is accepted, so the sustained rate is one word per cycle and the first
// word of the next message may follow the last word of the previous one directly.
// The parse state and result register are the only storage; msg.ready drops only while
// a finished result is held waiting for result.ready.
module tls_certificate_request_parser
  import tlscr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  tlscr_msg_if.sink         msg,
  tlscr_res_if.source       result
);

  typedef enum logic [3:0] {
    PH_HDR, PH_CTX, PH_CTX_SKIP, PH_XL_HI, PH_XL_LO,
    PH_EXT_HDR, PH_SA_HI, PH_SA_LO, PH_EXT_SKIP, PH_DONE
  } phase_t;

  phase_t             parse_phase, parse_phase_next;
  logic [PosW-1:0]    message_position, message_position_next;
  logic [BodyW-1:0]   body_length, body_length_next;
  logic [CtxW-1:0]    ctx_length, ctx_length_next;
  logic [XlenW-1:0]   extensions_length, extensions_length_next;
  logic [XposW-1:0]   extension_position, extension_position_next;
  logic [15:0]        field_counter, field_counter_next;
  logic [15:0]        extension_type, extension_type_next;
  logic [15:0]        extension_data_length, extension_data_length_next;
  logic               found_flag, found_flag_next;
  logic [OffsetW-1:0] found_offset, found_offset_next;
  logic [15:0]        found_length, found_length_next;
  logic               error_code, error_code_next;

  logic               accept;
  logic [StatusW-1:0] status_next;

  function automatic logic ext_end(input logic found, input logic [XlenW-1:0] xl,
                                   input logic [XposW-1:0] ep);
    logic [XposW-1:0] xl_ext;
    xl_ext = {1'b0, xl};
    return found || (xl_ext < ep) || ((xl_ext - ep) < XposW'(4));
  endfunction

  assign accept    = msg.valid && msg.ready;
  assign msg.ready = !result.valid || result.ready;

  always_comb begin
    logic [XposW-1:0] ep1;
    logic [15:0]      edl_new;
    logic [15:0]      sa;
    logic [15:0]      fc_dec;
    logic [XposW:0]   fit_sum;
    logic             fits;
    logic [PosW:0]    need_len;
    logic [PosW-1:0]  ctx_sum;
    logic [PosW-1:0]  frame_sum;

    parse_phase_next           = parse_phase;
    body_length_next           = body_length;
    ctx_length_next            = ctx_length;
    extensions_length_next     = extensions_length;
    extension_position_next    = extension_position;
    field_counter_next         = field_counter;
    extension_type_next        = extension_type;
    extension_data_length_next = extension_data_length;
    found_flag_next            = found_flag;
    found_offset_next          = found_offset;
    found_length_next          = found_length;
    error_code_next            = error_code;

    ep1     = extension_position + XposW'(1);
    edl_new = {extension_data_length[15:8], msg.data_byte};
    sa      = {field_counter[7:0], msg.data_byte};
    fc_dec  = field_counter - 16'd1;
    fit_sum = {1'b0, ep1} + (XposW + 1)'(edl_new);
    fits    = fit_sum <= (XposW + 1)'(extensions_length);

    if (message_position == '0) begin
      if (msg.data_byte != TYPE_CERT_REQ) error_code_next = 1'b1;
    end else if (message_position < PosW'(4)) begin
      body_length_next = {body_length[BodyW-9:0], msg.data_byte};
      if (message_position == PosW'(3)) parse_phase_next = PH_CTX;
    end else if ((message_position - PosW'(4)) < PosW'(body_length)) begin
      unique case (parse_phase)
        PH_CTX: begin
          ctx_length_next    = msg.data_byte;
          field_counter_next = 16'(msg.data_byte);
          parse_phase_next   = (msg.data_byte == 8'd0) ? PH_XL_HI : PH_CTX_SKIP;
        end
        PH_CTX_SKIP: begin
          field_counter_next = fc_dec;
          if (fc_dec == 16'd0) parse_phase_next = PH_XL_HI;
        end
        PH_XL_HI: begin
          extensions_length_next = {msg.data_byte, 8'd0};
          parse_phase_next       = PH_XL_LO;
        end
        PH_XL_LO: begin
          extensions_length_next  = {extensions_length[15:8], msg.data_byte};
          extension_position_next = '0;
          if (ext_end(found_flag, extensions_length_next, '0)) begin
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next   = PH_EXT_HDR;
            field_counter_next = '0;
          end
        end
        PH_EXT_HDR, PH_SA_HI, PH_SA_LO, PH_EXT_SKIP: begin
          extension_position_next = ep1;
          unique case (parse_phase)
            PH_EXT_HDR: begin
              unique case (field_counter[1:0])
                2'd0: extension_type_next = {msg.data_byte, 8'd0};
                2'd1: extension_type_next = {extension_type[15:8], msg.data_byte};
                2'd2: extension_data_length_next = {msg.data_byte, 8'd0};
                default: extension_data_length_next = edl_new;
              endcase
              field_counter_next = field_counter + 16'd1;
              if (field_counter[1:0] == 2'd3) begin
                if (extension_type == EXT_SIG_ALGS && fits && edl_new >= 16'd2) begin
                  parse_phase_next = PH_SA_HI;
                end else if (edl_new == 16'd0) begin
                  if (ext_end(found_flag, extensions_length, ep1)) begin
                    parse_phase_next = PH_DONE;
                  end else begin
                    parse_phase_next   = PH_EXT_HDR;
                    field_counter_next = '0;
                  end
                end else begin
                  field_counter_next = edl_new;
                  parse_phase_next   = PH_EXT_SKIP;
                end
              end
            end
            PH_SA_HI: begin
              field_counter_next = 16'(msg.data_byte);
              parse_phase_next   = PH_SA_LO;
            end
            PH_SA_LO: begin
              if ((17'(sa) + 17'd2) == 17'(extension_data_length)) begin
                found_flag_next   = 1'b1;
                found_offset_next = OffsetW'(message_position + PosW'(1));
                found_length_next = sa;
                parse_phase_next  = PH_DONE;
              end else begin
                field_counter_next = extension_data_length - 16'd2;
                if (field_counter_next == 16'd0) begin
                  if (ext_end(found_flag, extensions_length, ep1)) begin
                    parse_phase_next = PH_DONE;
                  end else begin
                    parse_phase_next   = PH_EXT_HDR;
                    field_counter_next = '0;
                  end
                end else begin
                  parse_phase_next = PH_EXT_SKIP;
                end
              end
            end
            default: begin
              field_counter_next = fc_dec;
              if (fc_dec == 16'd0) begin
                if (ext_end(found_flag, extensions_length, ep1)) begin
                  parse_phase_next = PH_DONE;
                end else begin
                  parse_phase_next   = PH_EXT_HDR;
                  field_counter_next = '0;
                end
              end
            end
          endcase
          if (parse_phase_next != PH_DONE && ep1 >= XposW'(extensions_length))
            parse_phase_next = PH_DONE;
        end
        default: ;
      endcase
    end

    message_position_next = (message_position == '1) ? message_position
                                                     : message_position + PosW'(1);

    need_len  = (PosW + 1)'(body_length_next) + (PosW + 1)'(4);
    ctx_sum   = PosW'(ctx_length_next) + PosW'(3);
    frame_sum = ctx_sum + PosW'(extensions_length_next);
    priority if (message_position_next < PosW'(4) || error_code_next
                 || (PosW + 1)'(message_position_next) < need_len)
      status_next = ST_BAD_HDR;
    else if (body_length_next == '0 || ctx_sum > PosW'(body_length_next)
             || frame_sum > PosW'(body_length_next))
      status_next = ST_BAD_FRAME;
    else if (found_flag_next)
      status_next = ST_OK;
    else
      status_next = ST_NO_LIST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase           <= PH_HDR;
      message_position      <= '0;
      body_length           <= '0;
      ctx_length            <= '0;
      extensions_length     <= '0;
      extension_position    <= '0;
      field_counter         <= '0;
      extension_type        <= '0;
      extension_data_length <= '0;
      found_flag            <= 1'b0;
      found_offset          <= '0;
      found_length          <= '0;
      error_code            <= 1'b0;
      result.valid          <= 1'b0;
      result.status         <= '0;
      result.context_length <= '0;
      result.schemes_offset <= '0;
      result.schemes_length <= '0;
    end else begin
      if (result.valid && result.ready) result.valid <= 1'b0;
      if (accept) begin
        if (msg.last_byte) begin
          parse_phase           <= PH_HDR;
          message_position      <= '0;
          body_length           <= '0;
          ctx_length            <= '0;
          extensions_length     <= '0;
          extension_position    <= '0;
          field_counter         <= '0;
          extension_type        <= '0;
          extension_data_length <= '0;
          found_flag            <= 1'b0;
          found_offset          <= '0;
          found_length          <= '0;
          error_code            <= 1'b0;
          result.valid          <= 1'b1;
          result.status         <= status_next;
          result.context_length <= (status_next == ST_OK || status_next == ST_NO_LIST)
                                   ? ctx_length_next : '0;
          result.schemes_offset <= (status_next == ST_OK) ? found_offset_next : '0;
          result.schemes_length <= (status_next == ST_OK) ? found_length_next : '0;
        end else begin
          parse_phase           <= parse_phase_next;
          message_position      <= message_position_next;
          body_length           <= body_length_next;
          ctx_length            <= ctx_length_next;
          extensions_length     <= extensions_length_next;
          extension_position    <= extension_position_next;
          field_counter         <= field_counter_next;
          extension_type        <= extension_type_next;
          extension_data_length <= extension_data_length_next;
          found_flag            <= found_flag_next;
          found_offset          <= found_offset_next;
          found_length          <= found_length_next;
          error_code            <= error_code_next;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(msg.valid && msg.ready && msg.last_byte))
    else $error("result appeared without a last word");

  a_unused_ctx_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_BAD_HDR || result.status == ST_BAD_FRAME)
      |-> result.context_length == '0)
    else $error("context length set on a header or framing error");

  a_found_ends_scan: assert property (@(posedge clk) disable iff (rst)
    found_flag |-> parse_phase == PH_DONE)
    else $error("scan continued after a scheme list was found");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !msg.ready)
    else $error("word taken while a result is held");
`endif

endmodule

`default_nettype wire
